@@ rtl/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and codes for the nearest palette colour search block.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int COLOR_W = 24;
	localparam int DIST_W  = 18;

	// Input opcodes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Command kinds after decode
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NOP   = 2'd0;
	localparam kind_t KIND_CLEAR = 2'd1;
	localparam kind_t KIND_ADD   = 2'd2;
	localparam kind_t KIND_QUERY = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		kind_t               kind;
		logic [COLOR_W-1:0]  color;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  color;
		logic [DIST_W-1:0]   dist_sq;
		logic                hit;
		logic [1:0]          status;
	} res_t;

endpackage

@@ rtl/npc_ram.sv @@
// ----------------------------------------------------------------------------
// npc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/npc_queue.sv @@
// ----------------------------------------------------------------------------
// npc_queue
// Two-entry register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module npc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/npc_front.sv @@
// ----------------------------------------------------------------------------
// npc_front
// Input side: decode each transfer into a command and hold it in a short
// queue until the search engine takes it.
// ----------------------------------------------------------------------------
module npc_front import npc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic [COLOR_W-1:0] color,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	cmd_t dec;
	logic cmd_empty;

	always_comb begin
		dec.color = color;
		case (opcode)
			OP_CLEAR: dec.kind = KIND_CLEAR;
			OP_ADD:   dec.kind = KIND_ADD;
			OP_QUERY: dec.kind = KIND_QUERY;
			default:  dec.kind = KIND_NOP;
		endcase
	end

	npc_queue #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

@@ rtl/npc_back.sv @@
// ----------------------------------------------------------------------------
// npc_back
// Search engine: holds the palette and entry count, scans the palette one
// entry per cycle for adds (duplicate check) and queries (nearest colour).
// ----------------------------------------------------------------------------
module npc_back import npc_pkg::*; #(
	parameter int PALETTE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_space,
	output logic res_push,
	output res_t res
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d * d;
	endfunction

	logic               state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_q;
	kind_t              kind_q;
	logic [COLOR_W-1:0] color_q;
	logic               have_best_q;
	logic [COLOR_W-1:0] best_q;
	logic [DIST_W-1:0]  best_d_q;

	logic               v_s1;
	logic               v_s2;
	logic [COLOR_W-1:0] c_s2;
	logic [15:0]        sq_r_s2;
	logic [15:0]        sq_g_s2;
	logic [15:0]        sq_b_s2;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [COLOR_W-1:0] ram_wdata;
	logic               ram_re;
	logic [COLOR_W-1:0] ram_rdata;

	logic               start;
	logic               scan_done;
	logic               go_scan;
	logic [DIST_W-1:0]  sum;
	logic               take;

	npc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		start     = (state_q == S_IDLE) && cmd_valid && res_space;
		scan_done = (state_q == S_SCAN) && (rd_q == count_q) && !v_s1 && !v_s2;
		ram_re    = (state_q == S_SCAN) && (rd_q < count_q);
		cmd_pop   = start;
		go_scan   = start && (count_q != '0)
			&& ((cmd.kind == KIND_ADD) || (cmd.kind == KIND_QUERY));

		sum  = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
		take = v_s2 && (!have_best_q || (sum < best_d_q)
			|| ((sum == best_d_q) && (c_s2 < best_q)));

		res_push     = 1'b0;
		res.color    = cmd.color;
		res.dist_sq  = '0;
		res.hit      = 1'b0;
		res.status   = STAT_OK;
		ram_we       = 1'b0;
		ram_waddr    = count_q[AW-1:0];
		ram_wdata    = cmd.color;

		if (start) begin
			case (cmd.kind)
				KIND_ADD: begin
					if (count_q == '0) begin
						// first entry needs no duplicate scan
						res_push  = 1'b1;
						ram_we    = 1'b1;
						ram_waddr = '0;
					end
				end
				KIND_QUERY: begin
					if (count_q == '0) begin
						res_push   = 1'b1;
						res.status = STAT_EMPTY;
					end
				end
				default: res_push = 1'b1;
			endcase
		end

		if (scan_done) begin
			res_push  = 1'b1;
			ram_wdata = color_q;
			if (kind_q == KIND_QUERY) begin
				res.color   = best_q;
				res.dist_sq = best_d_q;
				res.hit     = (best_d_q == '0);
			end else begin
				res.color = color_q;
				// a zero distance means the colour is already stored
				if (best_d_q != '0) begin
					if (count_q == CW'(PALETTE_DEPTH)) begin
						res.status = STAT_FULL;
					end else begin
						ram_we = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			if (start && (cmd.kind == KIND_CLEAR)) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (go_scan) begin
				state_q     <= S_SCAN;
				rd_q        <= '0;
				have_best_q <= 1'b0;
			end else if (scan_done) begin
				state_q <= S_IDLE;
			end else begin
				if (ram_re) begin
					rd_q <= rd_q + CW'(1);
				end
				if (take) begin
					have_best_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_scan) begin
			kind_q  <= cmd.kind;
			color_q <= cmd.color;
		end
		c_s2    <= ram_rdata;
		sq_r_s2 <= chan_sq(ram_rdata[23:16], color_q[23:16]);
		sq_g_s2 <= chan_sq(ram_rdata[15:8], color_q[15:8]);
		sq_b_s2 <= chan_sq(ram_rdata[7:0], color_q[7:0]);
		if (take) begin
			best_q   <= c_s2;
			best_d_q <= sum;
		end
	end

endmodule

@@ rtl/nearest_palette_color.sv @@
// Nearest palette colour search. Each transfer clears the palette, adds a
// colour, or queries the palette with a pixel; every transfer gives exactly
// one result, in order. Clear, unused opcodes, an add to an empty palette and
// a query on an empty palette are answered by the search engine without a
// scan. An add to, or a query on, a non-empty palette goes through these
// steps: take the command, read each entry from the single read port of the
// palette RAM, register the read data, the distance and compare stage, and
// hand the result over. Up to two commands queue ahead of the engine and up
// to two results queue behind it.
// ----------------------------------------------------------------------------
// nearest_palette_color
// Top level: command queue, search engine and result queue.
// ----------------------------------------------------------------------------
module nearest_palette_color import npc_pkg::*; #(
	parameter int PALETTE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic [COLOR_W-1:0] color,
	output logic               empty,
	input  logic               pop,
	output logic [COLOR_W-1:0] match_color,
	output logic [DIST_W-1:0]  distance_sq,
	output logic               exact_hit,
	output logic [1:0]         status
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res;
	res_t res_head;

	npc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.color     (color),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	npc_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_space (!res_full),
		.res_push  (res_push),
		.res       (res)
	);

	npc_queue #(
		.WIDTH ($bits(res_t))
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign match_color = res_head.color;
	assign distance_sq = res_head.dist_sq;
	assign exact_hit   = res_head.hit;
	assign status      = res_head.status;

endmodule

@@ rtl/npc_checker.sv @@
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette colour search block.
// ----------------------------------------------------------------------------
module npc_checker import npc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [COLOR_W-1:0] match_color,
	input logic [DIST_W-1:0]  distance_sq,
	input logic               exact_hit,
	input logic [1:0]         status
);

	// hold a waiting result until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(match_color) && $stable(distance_sq)
			&& $stable(exact_hit) && $stable(status)))
		else $error("result changed while waiting");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((status == STAT_OK) || (status == STAT_EMPTY) || (status == STAT_FULL)))
		else $error("unused status code");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status != STAT_OK)) |-> ((distance_sq == '0) && !exact_hit))
		else $error("failed item carries distance or hit");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && exact_hit) |-> ((distance_sq == '0) && (status == STAT_OK)))
		else $error("exact hit with non-zero distance");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (distance_sq <= DIST_W'(195075)))
		else $error("distance out of range");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);

@@ tb/nearest_palette_color_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_checker
// Watches both queue ports of the palette search block. It keeps its own
// palette, works out the result of every accepted command and compares each
// popped result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module nearest_palette_color_checker import npc_pkg::*; #(
	parameter int PALETTE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         opcode,
	input  logic [COLOR_W-1:0] color,
	input  logic               empty,
	input  logic               pop,
	input  logic [COLOR_W-1:0] match_color,
	input  logic [DIST_W-1:0]  distance_sq,
	input  logic               exact_hit,
	input  logic [1:0]         status,
	output int                 err_count,
	output int                 outstanding,
	output int                 checked_count,
	output int                 full_drops
);

	logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
	int                 palette_count;
	res_t               pending_results [$];

	function automatic int rgb_dist_sq(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
		int sum;
		int d;
		int ch;
		sum = 0;
		for (ch = 0; ch < 3; ch++) begin
			d = int'(a[ch*8 +: 8]) - int'(b[ch*8 +: 8]);
			sum += d * d;
		end
		return sum;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 50)
			$display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
		err_count++;
	endtask

	// Update the palette for one command and queue the result it must give.
	task automatic apply_command(input logic [1:0] op, input logic [COLOR_W-1:0] pix);
		res_t               r;
		logic               found;
		logic [COLOR_W-1:0] best;
		int                 best_d;
		int                 d;
		r.color   = pix;
		r.dist_sq = '0;
		r.hit     = 1'b0;
		r.status  = STAT_OK;
		case (op)
			OP_CLEAR: begin
				palette_count = 0;
			end
			OP_ADD: begin
				found = 1'b0;
				for (int k = 0; k < palette_count; k++)
					if (palette[k] == pix)
						found = 1'b1;
				if (!found) begin
					if (palette_count >= PALETTE_DEPTH) begin
						r.status = STAT_FULL;
						full_drops++;
					end else begin
						palette[palette_count] = pix;
						palette_count++;
					end
				end
			end
			OP_QUERY: begin
				if (palette_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					best   = palette[0];
					best_d = rgb_dist_sq(pix, best);
					for (int k = 1; k < palette_count; k++) begin
						d = rgb_dist_sq(pix, palette[k]);
						// equal distance: keep the numerically smaller colour
						if (d < best_d || (d == best_d && palette[k] < best)) begin
							best   = palette[k];
							best_d = d;
						end
					end
					r.color   = best;
					r.dist_sq = best_d[DIST_W-1:0];
					r.hit     = (best_d == 0);
				end
			end
			default: begin
			end
		endcase
		pending_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			pending_results.delete();
			palette_count = 0;
			err_count     = 0;
			checked_count = 0;
			full_drops    = 0;
		end else begin
			// compare first: a result can never belong to a command taken this cycle
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, colour", 32'(match_color), 32'h0);
				end else begin
					want = pending_results.pop_front();
					if (match_color !== want.color)
						report_mismatch("match_color", 32'(match_color), 32'(want.color));
					if (distance_sq !== want.dist_sq)
						report_mismatch("distance_sq", 32'(distance_sq), 32'(want.dist_sq));
					if (exact_hit !== want.hit)
						report_mismatch("exact_hit", 32'(exact_hit), 32'(want.hit));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
				checked_count++;
			end
			if (push && !full)
				apply_command(opcode, color);
		end
		outstanding = pending_results.size();
	end

endmodule

@@ tb/nearest_palette_color_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_tb
// Drives clear, add, query and unused-opcode commands into the palette search block:
// directed corner cases, then random palette sessions with exact, near, tied
// and random queries, under changing idle patterns and one long result stall.
// ----------------------------------------------------------------------------
module nearest_palette_color_tb;
	import npc_pkg::*;

	localparam int         DEPTH      = 64;
	localparam int         LIMIT      = 1_000_000;
	localparam int         ITEMS      = 1900;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	typedef logic [COLOR_W-1:0] rgb_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         opcode;
	rgb_t               color;
	logic               empty;
	logic               pop;
	rgb_t               match_color;
	logic [DIST_W-1:0]  distance_sq;
	logic               exact_hit;
	logic [1:0]         status;

	int err_count;
	int outstanding;
	int checked_count;
	int full_drops;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int cycle_count;
	int items_sent;
	int full_stalls;
	int op_count [4];
	rgb_t added [$];

	nearest_palette_color #(
		.PALETTE_DEPTH (DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.color       (color),
		.empty       (empty),
		.pop         (pop),
		.match_color (match_color),
		.distance_sq (distance_sq),
		.exact_hit   (exact_hit),
		.status      (status)
	);

	nearest_palette_color_checker #(
		.PALETTE_DEPTH (DEPTH)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.color         (color),
		.empty         (empty),
		.pop           (pop),
		.match_color   (match_color),
		.distance_sq   (distance_sq),
		.exact_hit     (exact_hit),
		.status        (status),
		.err_count     (err_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.full_drops    (full_drops)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random pops, or a counted hold-off when one is requested.
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one command and hold it until full is sampled low.
	task automatic send_item(input logic [1:0] op, input rgb_t c);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		opcode <= op;
		color  <= c;
		@(posedge clk);
		while (full !== 1'b0) begin
			full_stalls++;
			@(posedge clk);
		end
		op_count[op]++;
		if (op != OP_UNUSED)
			items_sent++;
		if (op == OP_CLEAR)
			added.delete();
		else if (op == OP_ADD)
			added.push_back(c);
	endtask

	// One palette session: clear, fill, then queries; or else a burst of noise.
	task automatic palette_session(input bit fill_up);
		int   n_adds;
		int   n_queries;
		int   ch;
		int   d;
		rgb_t c;
		rgb_t lo;
		rgb_t hi;
		if (!fill_up && $urandom_range(0, 7) == 0) begin
			// noise: any opcode, unused one included
			repeat ($urandom_range(1, 4))
				send_item(2'($urandom_range(0, 3)), rgb_t'($urandom()));
			return;
		end
		send_item(OP_CLEAR, rgb_t'($urandom()));
		if (fill_up || $urandom_range(0, 5) == 0)
			n_adds = $urandom_range(60, 72);
		else
			n_adds = $urandom_range(1, 12);
		repeat (n_adds) begin
			if (added.size() > 0 && $urandom_range(0, 4) == 0)
				c = added[$urandom_range(0, added.size() - 1)];
			else
				c = rgb_t'($urandom());
			send_item(OP_ADD, c);
		end
		n_queries = $urandom_range(2, 10);
		repeat (n_queries) begin
			case ($urandom_range(0, 3))
				0: begin
					send_item(OP_QUERY, added[$urandom_range(0, added.size() - 1)]);
				end
				1: begin
					// nudge each channel of a stored colour, saturating at the rails
					c = added[$urandom_range(0, added.size() - 1)];
					for (ch = 0; ch < 3; ch++) begin
						d = int'(c[ch*8 +: 8]) + $urandom_range(0, 6) - 3;
						c[ch*8 +: 8] = (d < 0) ? 8'd0 : (d > 255) ? 8'd255 : 8'(d);
					end
					send_item(OP_QUERY, c);
				end
				2: begin
					send_item(OP_QUERY, rgb_t'($urandom()));
				end
				default: begin
					// two colours equally far from the query along one channel
					c  = rgb_t'($urandom());
					ch = $urandom_range(0, 2);
					d  = $urandom_range(1, 7);
					if (int'(c[ch*8 +: 8]) < d)
						c[ch*8 +: 8] = 8'(d);
					else if (int'(c[ch*8 +: 8]) > 255 - d)
						c[ch*8 +: 8] = 8'(255 - d);
					lo = c;
					hi = c;
					lo[ch*8 +: 8] = c[ch*8 +: 8] - 8'(d);
					hi[ch*8 +: 8] = c[ch*8 +: 8] + 8'(d);
					send_item(OP_ADD, hi);
					send_item(OP_ADD, lo);
					send_item(OP_QUERY, c);
				end
			endcase
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		opcode        = OP_CLEAR;
		color         = '0;
		send_idle_pct = 34;
		recv_idle_pct = 60;
		hold_left     = 0;
		cycle_count   = 0;
		items_sent    = 0;
		full_stalls   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases
		send_item(OP_QUERY,  24'hFFFFFF);
		send_item(OP_UNUSED, 24'hA5A5A5);
		send_item(OP_ADD,    24'h000000);
		send_item(OP_ADD,    24'h000000);
		send_item(OP_QUERY,  24'hFFFFFF);
		send_item(OP_QUERY,  24'h000000);
		send_item(OP_ADD,    24'h000002);
		send_item(OP_QUERY,  24'h000001);
		send_item(OP_ADD,    24'hFFFFFF);
		send_item(OP_QUERY,  24'h7F7F7F);
		send_item(OP_ADD,    24'h123456);
		send_item(OP_QUERY,  24'h123457);
		send_item(OP_CLEAR,  24'h5A5A5A);
		send_item(OP_QUERY,  24'h010203);
		send_item(OP_ADD,    24'hFF0000);
		send_item(OP_QUERY,  24'hFE0101);

		palette_session(1'b1);
		while (items_sent < ITEMS / 3)
			palette_session(1'b0);

		send_idle_pct = 60;
		recv_idle_pct = 34;
		while (items_sent < 2 * ITEMS / 3)
			palette_session(1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// stall the result side while queries keep coming, so the input backs up
		palette_session(1'b1);
		hold_left = 600;
		repeat (12)
			send_item(OP_QUERY, rgb_t'($urandom()));
		while (items_sent < ITEMS)
			palette_session(1'b0);
		push <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("Ran %0d transfers: %0d clear, %0d add, %0d query, %0d unused opcode",
			op_count[0] + op_count[1] + op_count[2] + op_count[3],
			op_count[OP_CLEAR], op_count[OP_ADD], op_count[OP_QUERY], op_count[OP_UNUSED]);
		$display("Checked %0d results; %0d adds dropped on a full palette, %0d cycles held by full",
			checked_count, full_drops, full_stalls);
		if (err_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
